>>> design/kvtm_pkg.sv
// Package for the key=value token matcher.
// Holds character codes, position limits and configuration register indexes.
// No dependencies.
package kvtm_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 4;
    localparam int TEXT_W = 64;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_EQUALS = 8'h3D;

    localparam logic [POS_W-1:0] POSITION_LIMIT = 5'd31;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_TEXT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_TEXT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_LENGTH = 3'd3;

endpackage

>>> design/key_value_token_matcher.sv
// Top level of the key=value token matcher: token state, compare logic and result register.
// Depends on kvtm_pkg.
//
// Usage:
// - Input channel (in_valid/in_ready/character) takes one byte of a command line per beat.
//   Space and tab separate tokens; a NUL byte ends the string.
// - Output channel (out_valid/out_ready/found) gives one beat per NUL: found is 1 when some
//   token of the ended string equals key, '=', value exactly (case-sensitive).
// - Configuration port (cfg_write/cfg_index/cfg_data) writes key_text, key_length,
//   value_text and value_length with no wait; indexes beyond the list are ignored.
// Timing:
// - One byte is accepted per cycle while in_ready is high; each byte is compared and the
//   token state updated in the cycle it is taken, set by a single byte compare and a 5-bit position update.
// - The result of a NUL is registered and is on the output in the cycle after the NUL beat.
// - While a result waits and out_ready is low, in_ready is low; the result register holds.
//   Taking the result frees the input in the same cycle.
// Reset:
// - rst_n clears the registers, the token state and the result register at once.
module key_value_token_matcher
    import kvtm_pkg::*;
#(
    parameter int MAX_KEY_CHARS   = 8,
    parameter int MAX_VALUE_CHARS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CHAR_W-1:0]      character,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TEXT_W-1:0]      cfg_data
);

    localparam int KEY_BITS   = MAX_KEY_CHARS * CHAR_W;
    localparam int VALUE_BITS = MAX_VALUE_CHARS * CHAR_W;

    logic [KEY_BITS-1:0]   key_text_reg;
    logic [LEN_W-1:0]      key_length_reg;
    logic [VALUE_BITS-1:0] value_text_reg;
    logic [LEN_W-1:0]      value_length_reg;

    logic                  inside_token_reg;
    logic                  inside_token_next;
    logic [POS_W-1:0]      token_position_reg;
    logic [POS_W-1:0]      token_position_next;
    logic                  token_agrees_reg;
    logic                  token_agrees_next;
    logic                  match_seen_reg;
    logic                  match_seen_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  found_reg;
    logic                  found_next;

    logic                  in_beat;
    logic                  is_nul;
    logic                  is_separator;
    logic [LEN_W-1:0]      key_used;
    logic [LEN_W-1:0]      value_used;
    logic [POS_W-1:0]      token_total;
    logic [POS_W-1:0]      value_position;
    logic [CHAR_W-1:0]     key_byte;
    logic [CHAR_W-1:0]     value_byte;
    logic                  char_ok;
    logic                  close_hit;

    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_beat   = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;

    assign is_nul       = (character == CHAR_NUL);
    assign is_separator = (character == CHAR_SPACE) || (character == CHAR_TAB);

    assign key_used   = (key_length_reg > LEN_W'(MAX_KEY_CHARS)) ?
                        LEN_W'(MAX_KEY_CHARS) : key_length_reg;
    assign value_used = (value_length_reg > LEN_W'(MAX_VALUE_CHARS)) ?
                        LEN_W'(MAX_VALUE_CHARS) : value_length_reg;

    assign token_total    = POS_W'(key_used) + POS_W'(value_used) + POS_W'(1);
    assign value_position = token_position_reg - POS_W'(key_used) - POS_W'(1);

    always_comb
    begin
        key_byte = CHAR_NUL;
        for (int i = 0; i < MAX_KEY_CHARS; i++)
        begin
            if (token_position_reg == POS_W'(i))
            begin
                key_byte = key_text_reg[i*CHAR_W +: CHAR_W];
            end
        end
    end

    always_comb
    begin
        value_byte = CHAR_NUL;
        for (int i = 0; i < MAX_VALUE_CHARS; i++)
        begin
            if (value_position == POS_W'(i))
            begin
                value_byte = value_text_reg[i*CHAR_W +: CHAR_W];
            end
        end
    end

    always_comb
    begin
        if (token_position_reg < POS_W'(key_used))
        begin
            char_ok = (character == key_byte);
        end
        else if (token_position_reg == POS_W'(key_used))
        begin
            char_ok = (character == CHAR_EQUALS);
        end
        else if (token_position_reg < token_total)
        begin
            char_ok = (character == value_byte);
        end
        else
        begin
            char_ok = 1'b0;
        end
    end

    assign close_hit = inside_token_reg & token_agrees_reg & (token_position_reg == token_total);

    always_comb
    begin
        inside_token_next   = inside_token_reg;
        token_position_next = token_position_reg;
        token_agrees_next   = token_agrees_reg;
        match_seen_next     = match_seen_reg;
        found_next          = found_reg;
        out_valid_next      = out_valid_reg & ~out_ready;
        if (in_beat)
        begin
            if (is_nul)
            begin
                out_valid_next      = 1'b1;
                found_next          = match_seen_reg | close_hit;
                inside_token_next   = 1'b0;
                token_position_next = '0;
                token_agrees_next   = 1'b1;
                match_seen_next     = 1'b0;
            end
            else if (is_separator)
            begin
                match_seen_next     = match_seen_reg | close_hit;
                inside_token_next   = 1'b0;
                token_position_next = '0;
                token_agrees_next   = 1'b1;
            end
            else
            begin
                inside_token_next = 1'b1;
                token_agrees_next = token_agrees_reg & char_ok;
                if (token_position_reg < POSITION_LIMIT)
                begin
                    token_position_next = token_position_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_token_reg   <= 1'b0;
            token_position_reg <= '0;
            token_agrees_reg   <= 1'b1;
            match_seen_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
            found_reg          <= 1'b0;
        end
        else
        begin
            inside_token_reg   <= inside_token_next;
            token_position_reg <= token_position_next;
            token_agrees_reg   <= token_agrees_next;
            match_seen_reg     <= match_seen_next;
            out_valid_reg      <= out_valid_next;
            found_reg          <= found_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg     <= '0;
            key_length_reg   <= '0;
            value_text_reg   <= '0;
            value_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_TEXT:     key_text_reg     <= cfg_data[KEY_BITS-1:0];
                REG_KEY_LENGTH:   key_length_reg   <= cfg_data[LEN_W-1:0];
                REG_VALUE_TEXT:   value_text_reg   <= cfg_data[VALUE_BITS-1:0];
                REG_VALUE_LENGTH: value_length_reg <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_nul_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && is_nul) |=> out_valid_reg)
        else $error("NUL beat did not produce a result");

    a_result_from_nul: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_beat && is_nul))
        else $error("result appeared without a NUL beat");

    a_nul_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && is_nul) |=> (!inside_token_reg && token_position_reg == '0 &&
                                 token_agrees_reg && !match_seen_reg))
        else $error("string state not cleared after NUL");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(found_reg)))
        else $error("stalled result changed");
`endif

endmodule

>>> dv/tb_key_value_token_matcher.sv
// Self-checking testbench for the key=value token matcher: random stall driver, monitor and
// a token-level predictor of the found flag, across several key/value register settings.
// Depends on kvtm_pkg and key_value_token_matcher.
module tb_key_value_token_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import kvtm_pkg::*;

    localparam int KEY_CHARS_MAX   = 8;
    localparam int VALUE_CHARS_MAX = 8;
    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int MAX_GAP         = 12;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_NS      = 10_000_000;
    localparam string ALPHABET     = "abcAB=01";

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [CHAR_W-1:0]      character = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   found;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [TEXT_W-1:0]      cfg_data  = '0;

    key_value_token_matcher #(
        .MAX_KEY_CHARS  (KEY_CHARS_MAX),
        .MAX_VALUE_CHARS(VALUE_CHARS_MAX)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .character(character),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .found    (found),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predictor copy of the registers and token state
    logic [TEXT_W-1:0] key_text_q     = '0;
    logic [LEN_W-1:0]  key_len_q      = '0;
    logic [TEXT_W-1:0] value_text_q   = '0;
    logic [LEN_W-1:0]  value_len_q    = '0;
    bit                in_token_q     = 1'b0;
    logic [POS_W-1:0]  token_pos_q    = '0;
    bit                token_ok_q     = 1'b1;
    bit                match_seen_q   = 1'b0;

    logic [CHAR_W-1:0] pending_chars[$];
    logic              found_due[$];
    int unsigned       chars_queued = 0;
    int unsigned       chars_taken  = 0;
    int unsigned       mismatches   = 0;

    bit                in_beat   = 1'b0;
    bit                out_beat  = 1'b0;
    bit                in_calm   = 1'b0;
    bit                out_calm  = 1'b0;
    int unsigned       in_gap    = 0;
    int unsigned       out_gap   = 0;

    initial
    begin
        clk = 1'b0;
        forever #(HALF_PERIOD) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    function automatic int clamp_len(logic [LEN_W-1:0] n, int limit);
        return (int'(n) > limit) ? limit : int'(n);
    endfunction

    function automatic logic [CHAR_W-1:0] text_byte(logic [TEXT_W-1:0] t, int i);
        return t[(i % 8) * CHAR_W +: CHAR_W];
    endfunction

    function automatic logic [TEXT_W-1:0] pack_text(string s);
        logic [TEXT_W-1:0] t;
        t = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            t[i * CHAR_W +: CHAR_W] = s[i];
        return t;
    endfunction

    function automatic int unsigned gap_len(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic end_token();
        int total;
        total = clamp_len(key_len_q, KEY_CHARS_MAX) + 1 + clamp_len(value_len_q, VALUE_CHARS_MAX);
        if (in_token_q && token_ok_q && int'(token_pos_q) == total)
            match_seen_q = 1'b1;
        in_token_q  = 1'b0;
        token_pos_q = '0;
        token_ok_q  = 1'b1;
    endtask

    task automatic track_char(input logic [CHAR_W-1:0] c);
        int kl;
        int vl;
        int pos;
        bit ok;
        if (c == CHAR_NUL)
        begin
            end_token();
            found_due.push_back(match_seen_q);
            match_seen_q = 1'b0;
        end
        else if (c == CHAR_SPACE || c == CHAR_TAB)
        begin
            end_token();
        end
        else
        begin
            kl  = clamp_len(key_len_q, KEY_CHARS_MAX);
            vl  = clamp_len(value_len_q, VALUE_CHARS_MAX);
            pos = int'(token_pos_q);
            if (pos < kl)
                ok = (c == text_byte(key_text_q, pos));
            else if (pos == kl)
                ok = (c == CHAR_EQUALS);
            else if (pos < kl + 1 + vl)
                ok = (c == text_byte(value_text_q, pos - kl - 1));
            else
                ok = 1'b0;
            if (!ok)
                token_ok_q = 1'b0;
            in_token_q = 1'b1;
            if (token_pos_q < POSITION_LIMIT)
                token_pos_q = token_pos_q + 1'b1;
        end
    endtask

    // sender: hold each beat until taken, then wait a drawn gap
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_beat)
            begin
                if ($urandom_range(0, 39) == 0)
                    in_calm = !in_calm;
                in_gap = gap_len(in_calm);
            end
            if (!in_valid || in_beat)
            begin
                if (in_gap != 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() != 0)
                begin
                    character <= pending_chars.pop_front();
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall a drawn number of cycles before each result beat
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_ready && out_beat)
            begin
                if ($urandom_range(0, 39) == 0)
                    out_calm = !out_calm;
                out_gap = gap_len(out_calm);
            end
            if (out_gap != 0)
            begin
                out_gap = out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            in_beat  <= in_valid && in_ready;
            out_beat <= out_valid && out_ready;
            if (out_valid && out_ready)
            begin
                if (found_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: found %0d at %0t", found, $realtime);
                end
                else
                begin
                    want = found_due.pop_front();
                    if (found !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("found mismatch: expected %0d, got %0d at %0t",
                                     want, found, $realtime);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                chars_taken++;
                track_char(character);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TEXT_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_KEY_TEXT:     key_text_q   = data;
            REG_KEY_LENGTH:   key_len_q    = data[LEN_W-1:0];
            REG_VALUE_TEXT:   value_text_q = data;
            REG_VALUE_LENGTH: value_len_q  = data[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        while (chars_taken != chars_queued || found_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] c);
        pending_chars.push_back(c);
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    function automatic logic [CHAR_W-1:0] token_char();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 1) == 0)
            return ALPHABET[$urandom_range(0, ALPHABET.len() - 1)];
        do
            c = CHAR_W'($urandom_range(1, 255));
        while (c == CHAR_SPACE || c == CHAR_TAB);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] text_char();
        case ($urandom_range(0, 19))
            0:
            begin
                case ($urandom_range(0, 2))
                    0:       return CHAR_SPACE;
                    1:       return CHAR_TAB;
                    default: return CHAR_NUL;
                endcase
            end
            1, 2, 3: return CHAR_W'($urandom_range(1, 255));
            default: return ALPHABET[$urandom_range(0, ALPHABET.len() - 1)];
        endcase
    endfunction

    function automatic int pick_length();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 8;
            2:       return $urandom_range(9, 15);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic program_random_config();
        logic [TEXT_W-1:0] kt;
        logic [TEXT_W-1:0] vt;
        logic [TEXT_W-1:0] kl_word;
        logic [TEXT_W-1:0] vl_word;
        int kl;
        int vl;
        kl = pick_length();
        vl = pick_length();
        kt = {$urandom, $urandom};
        vt = {$urandom, $urandom};
        kl_word = {$urandom, $urandom};
        vl_word = {$urandom, $urandom};
        kl_word[LEN_W-1:0] = LEN_W'(kl);
        vl_word[LEN_W-1:0] = LEN_W'(vl);
        for (int i = 0; i < kl && i < KEY_CHARS_MAX; i++)
            kt[i * CHAR_W +: CHAR_W] = text_char();
        for (int i = 0; i < vl && i < VALUE_CHARS_MAX; i++)
            vt[i * CHAR_W +: CHAR_W] = text_char();
        write_reg(REG_KEY_TEXT, kt);
        write_reg(REG_KEY_LENGTH, kl_word);
        write_reg(REG_VALUE_TEXT, vt);
        write_reg(REG_VALUE_LENGTH, vl_word);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_VALUE_LENGTH + CFG_INDEX_W'($urandom_range(1, 4)),
                      {$urandom, $urandom});
    endtask

    task automatic push_gap();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) push_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    endtask

    task automatic push_token(input int kind);
        logic [CHAR_W-1:0] tok[$];
        int kl;
        int vl;
        int k;
        int n;
        kl = clamp_len(key_len_q, KEY_CHARS_MAX);
        vl = clamp_len(value_len_q, VALUE_CHARS_MAX);
        for (k = 0; k < kl; k++)
            tok.push_back(text_byte(key_text_q, k));
        tok.push_back(CHAR_EQUALS);
        for (k = 0; k < vl; k++)
            tok.push_back(text_byte(value_text_q, k));
        case (kind)
            4:
            begin
                k = $urandom_range(0, tok.size() - 1);
                tok[k] = token_char();
            end
            5:
            begin
                n = $urandom_range(1, tok.size());
                repeat (n) void'(tok.pop_back());
            end
            6:
            begin
                n = $urandom_range(1, 3);
                repeat (n) tok.push_back(token_char());
            end
            7:
            begin
                k = $urandom_range(0, tok.size() - 1);
                tok[k] = tok[k] ^ 8'h20;
            end
            8:
            begin
                n = $urandom_range(20, 40);
                repeat (n) tok.push_back(token_char());
            end
            9:
            begin
                tok.delete();
                n = $urandom_range(1, 6);
                repeat (n) tok.push_back(token_char());
            end
            default: ;
        endcase
        foreach (tok[j])
            push_char(tok[j]);
    endtask

    task automatic push_line();
        int n;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 20);
            repeat (n) push_char(CHAR_W'($urandom_range(0, 255)));
            push_char(CHAR_NUL);
            return;
        end
        if ($urandom_range(0, 3) == 0)
            push_gap();
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
        begin
            push_token($urandom_range(0, 9));
            if (i < n - 1 || $urandom_range(0, 2) == 0)
                push_gap();
        end
        push_char(CHAR_NUL);
    endtask

    initial
    begin
        int unsigned directed_end;
        int unsigned phase_end;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(REG_KEY_TEXT, pack_text("ab"));
        write_reg(REG_KEY_LENGTH, 64'd2);
        write_reg(REG_VALUE_TEXT, pack_text("1"));
        write_reg(REG_VALUE_LENGTH, 64'd1);
        push_text("ab=1");
        push_char(CHAR_NUL);
        push_char(8'hFF);
        push_text(" ab=1x");
        push_char(CHAR_NUL);
        push_char(CHAR_NUL);
        wait_idle();

        write_reg(REG_KEY_LENGTH, '0);
        write_reg(REG_VALUE_LENGTH, '0);
        push_text("\t= ");
        push_char(CHAR_NUL);
        wait_idle();

        write_reg(REG_KEY_TEXT, pack_text("abcdefgh"));
        write_reg(REG_KEY_LENGTH, '1);
        write_reg(REG_VALUE_LENGTH + 1'b1, '0);
        push_text("abcdefgh=");
        push_char(CHAR_NUL);
        directed_end = chars_queued;

        while (chars_queued - directed_end < RANDOM_ITEMS)
        begin
            wait_idle();
            program_random_config();
            phase_end = chars_queued + $urandom_range(40, 160);
            while (chars_queued < phase_end)
                push_line();
            if ($urandom_range(0, 3) == 0)
            begin
                push_token($urandom_range(0, 9));
                if ($urandom_range(0, 1) == 0)
                    push_gap();
            end
        end

        while (chars_taken != chars_queued || found_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
